// File: design/assert_macros.svh
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define RVCL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset
`define RVCL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/rvcl_pkg.sv
`default_nettype none
package rvcl_pkg;

    // result width and saturation limit
    localparam int CHORD_W = 17;
    localparam logic [CHORD_W-1:0] CHORD_MAX = 17'h1FFFF;

    // output tdata width (chord padded to whole bytes)
    localparam int OUT_TDATA_W = ((CHORD_W + 7) / 8) * 8;

    // configuration register index width and codes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } t_cfg_idx;

    // reset voxel size: 1.0 with 8 fraction bits
    localparam int SIZE_RESET = 256;

endpackage
`default_nettype wire

// File: design/ray_voxel_chord_length.sv
`default_nettype none
// Channel  Direction  Handshake                 Payload
// s_*      in         s_tvalid / s_tready       tdata: dir_x, dir_y, dir_z
// m_*      out        m_tvalid / m_tready       tdata: chord_length; tuser: no_hit
// i_cfg_*  in         i_cfg_wr_en (no wait)     index 0..2 -> voxel_size_x/y/z
//
// One item per cycle while m_* is not stalled. Stages: five front stages
// (magnitudes, products, face select, size square, radicand), one square-root
// cell and one divider cell per root bit, and the output register.
// Reset (synchronous, active low) empties the pipeline and sets all sizes to 1.0.
// A stall at m_* freezes the whole pipeline; s_tready drops only while the
// output register holds an item that is not taken.
module ray_voxel_chord_length #(
    parameter int DIR_WIDTH  = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [rvcl_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [SIZE_WIDTH-1:0]                  i_cfg_data,
    // input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // dir_x, dir_y, dir_z from bit 0 up, zero padded
    input  wire logic [((3*DIR_WIDTH+7)/8)*8-1:0]       s_tdata,
    // output stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // chord_length from bit 0 up, zero padded
    output logic [rvcl_pkg::OUT_TDATA_W-1:0]            m_tdata,
    // no_hit
    output logic                                        m_tuser
);

    localparam int DW  = DIR_WIDTH;
    localparam int SW  = SIZE_WIDTH;
    localparam int PW  = SW + DW;
    localparam int NW  = 2 * DW;
    localparam int QW  = SW + DW + 1;
    localparam int RW  = 2 * QW;
    localparam int CW  = rvcl_pkg::CHORD_W;
    localparam int SBW = DW + 1;

    // pipeline advance
    logic r_o_vld;
    logic en;
    assign en       = !r_o_vld || m_tready;
    assign s_tready = en;

    // configuration registers
    logic [SW-1:0] r_size_x, r_size_y, r_size_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SW'(rvcl_pkg::SIZE_RESET);
            r_size_y <= SW'(rvcl_pkg::SIZE_RESET);
            r_size_z <= SW'(rvcl_pkg::SIZE_RESET);
        end else if (i_cfg_wr_en) begin
            case (rvcl_pkg::t_cfg_idx'(i_cfg_idx))
                rvcl_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data;
                rvcl_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data;
                rvcl_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: component magnitudes
    logic [DW-1:0] dx, dy, dz;
    assign dx = s_tdata[DW-1:0];
    assign dy = s_tdata[2*DW-1:DW];
    assign dz = s_tdata[3*DW-1:2*DW];

    logic          r1_vld;
    logic [DW-1:0] r1_ax, r1_ay, r1_az;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_tvalid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ax <= dx[DW-1] ? (~dx + 1'b1) : dx;
            r1_ay <= dy[DW-1] ? (~dy + 1'b1) : dy;
            r1_az <= dz[DW-1] ? (~dz + 1'b1) : dz;
        end
    end

    // stage 2: face-test cross products and squares
    logic          r2_vld;
    logic [PW-1:0] r2_xy, r2_yx, r2_xz, r2_zx, r2_yz, r2_zy;
    logic [NW-1:0] r2_qx, r2_qy, r2_qz;
    logic [DW-1:0] r2_ax, r2_ay, r2_az;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_xy <= PW'(r_size_x) * PW'(r1_ay);
            r2_yx <= PW'(r_size_y) * PW'(r1_ax);
            r2_xz <= PW'(r_size_x) * PW'(r1_az);
            r2_zx <= PW'(r_size_z) * PW'(r1_ax);
            r2_yz <= PW'(r_size_y) * PW'(r1_az);
            r2_zy <= PW'(r_size_z) * PW'(r1_ay);
            r2_qx <= NW'(r1_ax) * NW'(r1_ax);
            r2_qy <= NW'(r1_ay) * NW'(r1_ay);
            r2_qz <= NW'(r1_az) * NW'(r1_az);
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
            r2_az <= r1_az;
        end
    end

    // stage 3: face select (x, then y, then z) and squared norm
    logic hit_x, hit_y, hit_z;
    assign hit_x = (r2_ax != '0) && (r2_xy <= r2_yx) && (r2_xz <= r2_zx);
    assign hit_y = (r2_ay != '0) && (r2_yx <= r2_xy) && (r2_yz <= r2_zy);
    assign hit_z = (r2_az != '0) && (r2_zy <= r2_yz) && (r2_zx <= r2_xz);

    logic          r3_vld, r3_hit;
    logic [SW-1:0] r3_s;
    logic [DW-1:0] r3_a;
    logic [NW-1:0] r3_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_n   <= r2_qx + r2_qy + r2_qz;
            r3_hit <= hit_x || hit_y || hit_z;
            if (hit_x) begin
                r3_s <= r_size_x;
                r3_a <= r2_ax;
            end else if (hit_y) begin
                r3_s <= r_size_y;
                r3_a <= r2_ay;
            end else begin
                r3_s <= r_size_z;
                r3_a <= r2_az;
            end
        end
    end

    // stage 4: size squared
    logic            r4_vld, r4_hit;
    logic [2*SW-1:0] r4_s2;
    logic [DW-1:0]   r4_a;
    logic [NW-1:0]   r4_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_s2  <= (2*SW)'(r3_s) * (2*SW)'(r3_s);
            r4_a   <= r3_a;
            r4_n   <= r3_n;
            r4_hit <= r3_hit;
        end
    end

    // stage 5: radicand 4*s^2*n
    logic          r5_vld, r5_hit;
    logic [RW-1:0] r5_rad;
    logic [DW-1:0] r5_a;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_rad <= {(RW-2)'(r4_s2) * (RW-2)'(r4_n), 2'b00};
            r5_a   <= r4_a;
            r5_hit <= r4_hit;
        end
    end

    // square-root chain: r = floor(sqrt(4*s^2*n))
    logic          sq_vld  [0:QW];
    logic [QW+1:0] sq_rem  [0:QW];
    logic [QW-1:0] sq_root [0:QW];
    logic [RW-1:0] sq_rad  [0:QW];
    logic [SBW-1:0] sq_sb  [0:QW];

    assign sq_vld[0]  = r5_vld;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r5_rad;
    assign sq_sb[0]   = {r5_hit, r5_a};

    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        rvcl_sqrt_cell #(.QW(QW), .SBW(SBW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (sq_vld[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_rad  (sq_rad[g]),
            .i_sb   (sq_sb[g]),
            .o_vld  (sq_vld[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_rad  (sq_rad[g+1]),
            .o_sb   (sq_sb[g+1])
        );
    end

    // divider chain: floor(r / a)
    logic          dv_vld [0:QW];
    logic [DW-1:0] dv_rem [0:QW];
    logic [QW-1:0] dv_dvd [0:QW];
    logic [DW-1:0] dv_dvs [0:QW];
    logic          dv_hit [0:QW];

    assign dv_vld[0] = sq_vld[QW];
    assign dv_rem[0] = '0;
    assign dv_dvd[0] = sq_root[QW];
    assign dv_dvs[0] = sq_sb[QW][DW-1:0];
    assign dv_hit[0] = sq_sb[QW][DW];

    for (genvar g = 0; g < QW; g++) begin : g_div
        rvcl_div_cell #(.QW(QW), .DW(DW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (dv_vld[g]),
            .i_rem  (dv_rem[g]),
            .i_dvd  (dv_dvd[g]),
            .i_dvs  (dv_dvs[g]),
            .i_hit  (dv_hit[g]),
            .o_vld  (dv_vld[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_dvd  (dv_dvd[g+1]),
            .o_dvs  (dv_dvs[g+1]),
            .o_hit  (dv_hit[g+1])
        );
    end

    // round: q = (floor(r/a) + 1) / 2, then saturate
    logic [QW:0]   q_full;
    logic [CW-1:0] q_sat;
    always_comb begin
        q_full = ({1'b0, dv_dvd[QW]} + 1'b1) >> 1;
        if (q_full > (QW+1)'(rvcl_pkg::CHORD_MAX)) begin
            q_sat = rvcl_pkg::CHORD_MAX;
        end else begin
            q_sat = CW'(q_full);
        end
    end

    // output register
    logic [CW-1:0] r_o_chord;
    logic          r_o_nohit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= dv_vld[QW];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_chord <= dv_hit[QW] ? q_sat : '0;
            r_o_nohit <= !dv_hit[QW];
        end
    end

    assign m_tvalid = r_o_vld;
    assign m_tdata  = rvcl_pkg::OUT_TDATA_W'(r_o_chord);
    assign m_tuser  = r_o_nohit;

endmodule
`default_nettype wire

// File: design/rvcl_sqrt_cell.sv
`default_nettype none
// One digit of a restoring integer square root; one root bit per cell
module rvcl_sqrt_cell #(
    parameter int QW  = 33,
    parameter int SBW = 17
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire logic [QW+1:0]   i_rem,
    input  wire logic [QW-1:0]   i_root,
    input  wire logic [2*QW-1:0] i_rad,
    input  wire logic [SBW-1:0]  i_sb,
    output logic                 o_vld,
    output logic [QW+1:0]        o_rem,
    output logic [QW-1:0]        o_root,
    output logic [2*QW-1:0]      o_rad,
    output logic [SBW-1:0]       o_sb
);

    localparam int RW = 2 * QW;
    localparam int CW = QW + 4;

    logic          r_vld;
    logic [QW+1:0] r_rem;
    logic [QW-1:0] r_root;
    logic [RW-1:0] r_rad;
    logic [SBW-1:0] r_sb;

    logic [CW-1:0] cur;
    logic [CW-1:0] trial;
    logic          ge;
    logic [CW-1:0] diff;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        cur   = {i_rem, i_rad[RW-1:RW-2]};
        trial = {2'b00, i_root, 2'b01};
        ge    = (cur >= trial);
        diff  = cur - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? diff[QW+1:0] : cur[QW+1:0];
            r_root <= {i_root[QW-2:0], ge};
            r_rad  <= {i_rad[RW-3:0], 2'b00};
            r_sb   <= i_sb;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_sb   = r_sb;

endmodule
`default_nettype wire

// File: design/rvcl_div_cell.sv
`default_nettype none
// One step of a restoring divider; one quotient bit per cell
module rvcl_div_cell #(
    parameter int QW = 33,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_dvd,
    input  wire logic [DW-1:0] i_dvs,
    input  wire logic          i_hit,
    output logic               o_vld,
    output logic [DW-1:0]      o_rem,
    output logic [QW-1:0]      o_dvd,
    output logic [DW-1:0]      o_dvs,
    output logic               o_hit
);

    logic          r_vld;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_dvd;
    logic [DW-1:0] r_dvs;
    logic          r_hit;

    logic [DW:0] cur;
    logic [DW:0] diff;
    logic        ge;

    // shift in the next dividend bit and try to subtract the divisor
    always_comb begin
        cur  = {i_rem, i_dvd[QW-1]};
        ge   = (cur >= {1'b0, i_dvs});
        diff = cur - {1'b0, i_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // quotient bits enter at the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? diff[DW-1:0] : cur[DW-1:0];
            r_dvd <= {i_dvd[QW-2:0], ge};
            r_dvs <= i_dvs;
            r_hit <= i_hit;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_dvd = r_dvd;
    assign o_dvs = r_dvs;
    assign o_hit = r_hit;

endmodule
`default_nettype wire

// File: design/rvcl_chk.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the chord length block
module rvcl_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [rvcl_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input wire logic                               m_tuser,
    input wire logic                               s_tready
);

    // a missed face always reports zero length
    `RVCL_ASSERT(a_nohit_zero, i_clk, i_rst_n, (m_tvalid && m_tuser) |-> (m_tdata == '0), "no_hit item with nonzero chord")

    // padding above the chord stays zero
    `RVCL_ASSERT(a_pad_zero, i_clk, i_rst_n, m_tvalid |-> (m_tdata[rvcl_pkg::OUT_TDATA_W-1:rvcl_pkg::CHORD_W] == '0), "chord padding not zero")

    // the input side stalls only behind a held result
    `RVCL_ASSERT(a_ready_stall, i_clk, i_rst_n, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")

    // a held result does not change
    `RVCL_ASSERT(a_out_hold, i_clk, i_rst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "held result changed")

    // reset empties the output register
    `RVCL_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_tvalid, "result present after reset")

endmodule

bind ray_voxel_chord_length rvcl_chk u_rvcl_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .s_tready(s_tready)
);
`default_nettype wire

// File: dv/ray_voxel_chord_length_test.sv
`default_nettype none
module ray_voxel_chord_length_test;

    localparam int DW = 16;
    localparam int SW = 16;
    localparam int PIPE_LAT = 6 + 2 * (SW + DW + 1);
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    // expected chord lengths for the rays in flight, plus the voxel size copy
    class chord_scoreboard;
        logic [SW-1:0] size_x = SW'(rvcl_pkg::SIZE_RESET);
        logic [SW-1:0] size_y = SW'(rvcl_pkg::SIZE_RESET);
        logic [SW-1:0] size_z = SW'(rvcl_pkg::SIZE_RESET);
        logic [rvcl_pkg::CHORD_W-1:0] exp_len[$];
        bit exp_miss[$];
        int errors = 0;
        int rays_in = 0;
        int results = 0;
        int misses = 0;

        // (2q-1)^2 a^2 / 4, rounded up, against s^2 n
        function bit half_below(longint unsigned q, longint unsigned a,
                                longint unsigned s, longint unsigned n);
            logic [127:0] l;
            logic [127:0] lhs;
            logic [127:0] rhs;
            l = (2 * q - 1) * a;
            lhs = (l * l + 3) >> 2;
            rhs = (128'(s) * 128'(s)) * 128'(n);
            return lhs <= rhs;
        endfunction

        // nearest 1/256 of s*|dir|/a, saturating at CHORD_MAX
        function logic [rvcl_pkg::CHORD_W-1:0] chord_of(longint unsigned s,
                                                        longint unsigned a,
                                                        longint unsigned n);
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            lo = 0;
            hi = longint'(rvcl_pkg::CHORD_MAX);
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                if (half_below(mid, a, s, n)) lo = mid;
                else hi = mid - 1;
            end
            return lo[rvcl_pkg::CHORD_W-1:0];
        endfunction

        function void note_ray(logic signed [DW-1:0] dx, logic signed [DW-1:0] dy,
                               logic signed [DW-1:0] dz);
            longint unsigned ax, ay, az, sx, sy, sz, n;
            ax = dx < 0 ? -longint'(dx) : longint'(dx);
            ay = dy < 0 ? -longint'(dy) : longint'(dy);
            az = dz < 0 ? -longint'(dz) : longint'(dz);
            sx = size_x;
            sy = size_y;
            sz = size_z;
            n = ax * ax + ay * ay + az * az;
            rays_in++;
            // faces tried x, y, z
            if (ax != 0 && sx * ay <= sy * ax && sx * az <= sz * ax) begin
                exp_len.push_back(chord_of(sx, ax, n));
                exp_miss.push_back(1'b0);
            end else if (ay != 0 && sy * ax <= sx * ay && sy * az <= sz * ay) begin
                exp_len.push_back(chord_of(sy, ay, n));
                exp_miss.push_back(1'b0);
            end else if (az != 0 && sz * ay <= sy * az && sz * ax <= sx * az) begin
                exp_len.push_back(chord_of(sz, az, n));
                exp_miss.push_back(1'b0);
            end else begin
                exp_len.push_back('0);
                exp_miss.push_back(1'b1);
            end
        endfunction

        function void check_result(logic [rvcl_pkg::CHORD_W-1:0] len, logic miss);
            logic [rvcl_pkg::CHORD_W-1:0] el;
            bit em;
            results++;
            if (exp_len.size() == 0) begin
                $error("result with no ray outstanding: chord_length %0d no_hit %0d",
                       len, miss);
                errors++;
                return;
            end
            el = exp_len.pop_front();
            em = exp_miss.pop_front();
            if (em) misses++;
            if (len !== el) begin
                $error("chord_length: expected %0d, got %0d", el, len);
                errors++;
            end
            if (miss !== em) begin
                $error("no_hit: expected %0d, got %0d", em, miss);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [rvcl_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SW-1:0] i_cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rvcl_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    chord_scoreboard sb = new();
    bit jitter = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_cnt = 0;
    int cfg_writes = 0;

    always #1 i_clk = ~i_clk;

    ray_voxel_chord_length #(.DIR_WIDTH(DW), .SIZE_WIDTH(SW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // result side: check, random back-pressure, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[rvcl_pkg::CHORD_W-1:0], m_tuser);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) hold_left--;
            m_tready <= (hold_left == 0) && !(jitter && $urandom_range(99) < 10);
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_ray(logic signed [DW-1:0] dx, logic signed [DW-1:0] dy,
                            logic signed [DW-1:0] dz);
        while (jitter && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dz, dy, dx};
        do @(posedge i_clk); while (!s_tready);
        sb.note_ray(dx, dy, dz);
    endtask

    // let the pipeline drain before touching the sizes
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_len.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
    endtask

    // one register write; the enable is dropped by the caller
    task automatic cfg_write(rvcl_pkg::t_cfg_idx idx, logic [SW-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            rvcl_pkg::CFG_SIZE_X: sb.size_x = val;
            rvcl_pkg::CFG_SIZE_Y: sb.size_y = val;
            default:              sb.size_z = val;
        endcase
        cfg_writes++;
    endtask

    task automatic set_sizes(logic [SW-1:0] sx, logic [SW-1:0] sy, logic [SW-1:0] sz);
        cfg_write(rvcl_pkg::CFG_SIZE_X, sx);
        cfg_write(rvcl_pkg::CFG_SIZE_Y, sy);
        cfg_write(rvcl_pkg::CFG_SIZE_Z, sz);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return '0;
            1: return $urandom_range(1) ? DW'($urandom_range(15))
                                        : DW'(-$urandom_range(15));
            2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic random_rays(int count);
        for (int k = 0; k < count; k++) begin
            // one pause, halfway through, until every result is back
            if (k == count / 2) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (sb.exp_len.size() != 0) @(posedge i_clk);
            end
            send_ray(rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    function automatic logic [SW-1:0] rand_size();
        case ($urandom_range(3))
            0: return SW'($urandom_range(1, 16));
            1: return SW'($urandom_range(65520, 65535));
            default: return SW'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero ray, axis extremes, diagonals, face ties
        send_ray(16'sd0, 16'sd0, 16'sd0);
        send_ray(16'sh7FFF, 16'sd0, 16'sd0);
        send_ray(16'sh8000, 16'sd0, 16'sd0);
        send_ray(16'sd0, 16'sh7FFF, 16'sd0);
        send_ray(16'sd0, 16'sh8000, 16'sd0);
        send_ray(16'sd0, 16'sd0, 16'sh7FFF);
        send_ray(16'sd0, 16'sd0, 16'sh8000);
        send_ray(16'sh8000, 16'sh8000, 16'sh8000);
        send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_ray(16'sd1, 16'sd1, 16'sd0);
        send_ray(16'sd0, -16'sd1, 16'sd1);
        send_ray(16'sd1, -16'sd1, 16'sd1);
        send_ray(16'sd3, 16'sd4, 16'sd0);
        send_ray(16'sd1, 16'sd2, 16'sd2);
        send_ray(-16'sd1, 16'sd0, 16'sd0);
        send_ray(16'sh8000, 16'sd1, -16'sd1);
        send_ray(16'sh5555, 16'shAAAA, 16'sh0F0F);
        drain();

        // extreme sizes
        set_sizes(16'hFFFF, 16'd1, 16'd1);
        send_ray(16'sd1, 16'sh8000, 16'sh8000);
        send_ray(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_ray(16'sd0, 16'sd0, 16'sd0);
        send_ray(16'sh8000, 16'sh7FFF, 16'sh8000);
        random_rays(60);
        drain();
        set_sizes(16'd1, 16'd1, 16'd1);
        random_rays(60);
        drain();
        set_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_rays(80);
        drain();

        // long receiver hold-off while rays keep coming
        set_sizes(16'd1, 16'hFFFF, 16'd256);
        hold_req = 1'b1;
        jitter = 1'b0;
        random_rays(150);
        jitter = 1'b1;
        drain();

        // random sizes
        for (int p = 0; p < 6; p++) begin
            set_sizes(rand_size(), rand_size(), rand_size());
            random_rays(110);
            drain();
        end

        $display("Covered %0d rays, %0d results (%0d with no_hit), %0d size writes.",
                 sb.rays_in, sb.results, sb.misses, cfg_writes);
        $display("Size settings spanned 1 to 65535 per axis, with stalls on both sides.");
        if (sb.errors == 0 && sb.exp_len.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/rvcl_pkg.sv
design/rvcl_sqrt_cell.sv
design/rvcl_div_cell.sv
design/ray_voxel_chord_length.sv
design/rvcl_chk.sv
dv/ray_voxel_chord_length_test.sv
